// ===== src/anb_pkg.sv =====
package anb_pkg;

  // counter widths
  localparam int SIZE_BITS      = 24;
  localparam int EPB_COUNT_BITS = 16;

  // fixed field widths of the result request
  localparam int POS_W   = 24;
  localparam int SIZE_W  = 24;
  localparam int COUNT_W = 16;
  localparam int TYPE_W  = 5;

  // stream byte codes
  localparam logic [7:0] STC_BYTE  = 8'h01;
  localparam logic [7:0] EPB_BYTE  = 8'h03;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [1:0] ZERO_RUN_FULL = 2'd2;

  localparam logic [SIZE_BITS-1:0]      SIZE_MAX  = '1;
  localparam logic [EPB_COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SIZE_BITS-1:0]      HDR_INDEX = SIZE_BITS'(1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EPB     = 2'd1,
    KIND_NAL_END = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } anb_in_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic [POS_W-1:0]   epb_position;
    logic [TYPE_W-1:0]  nal_type;
    logic [SIZE_W-1:0]  nal_size;
    logic [COUNT_W-1:0] epb_count;
  } anb_out_t;

  // parser state carried between bytes
  typedef struct packed {
    logic [1:0]                zero_run;
    logic                      unit_open;
    logic [SIZE_BITS-1:0]      payload_count;
    logic [EPB_COUNT_BITS-1:0] removed_count;
    logic [TYPE_W-1:0]         header_type;
  } anb_state_t;

  localparam anb_state_t STATE_RESET = '{
    zero_run:      2'd0,
    unit_open:     1'b0,
    payload_count: '0,
    removed_count: '0,
    header_type:   '0
  };

endpackage

// ===== src/annexb_nal_extractor.sv =====
// a result is registered and shown in the cycle after its byte request is accepted
// throughput: one byte per cycle while no result waits; anb_step updates state
// the result register frees the input side as soon as the result is taken
// reset: synchronous, active high; clears parser state and the result valid,
// no unit is open until the first start code
module annexb_nal_extractor (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  anb_pkg::anb_in_t  byte_req,
  output logic              res_valid,
  input  logic              res_ready,
  output anb_pkg::anb_out_t res_req
);
  import anb_pkg::*;

  anb_state_t st;
  anb_state_t st_next;
  logic       emit;
  anb_out_t   res_next;
  logic       accept;

  anb_step u_step (
    .st      (st),
    .item    (byte_req),
    .st_next (st_next),
    .emit    (emit),
    .res     (res_next)
  );

  // take a byte whenever the result register is free or being emptied
  assign byte_ready = !res_valid || res_ready;
  assign accept     = byte_valid && byte_ready;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_req <= res_next;
    end
  end

  // closed or never-opened unit holds no counts
  a_idle_counts: assert property (@(posedge clk) disable iff (rst)
    !st.unit_open |-> (st.payload_count == '0 && st.removed_count == '0))
    else $error("counts nonzero with no open unit");

  // zero run saturates at two
  a_zero_run: assert property (@(posedge clk) disable iff (rst)
    st.zero_run != 2'd3)
    else $error("zero run out of range");

  // end of stream always leaves no unit open
  a_eos_close: assert property (@(posedge clk) disable iff (rst)
    accept && byte_req.end_of_stream |=> !st.unit_open)
    else $error("unit still open after end of stream");

  // an open unit always yields a result for an end of stream request
  a_eos_result: assert property (@(posedge clk) disable iff (rst)
    accept && byte_req.end_of_stream && st.unit_open |=>
      res_valid && res_req.kind == KIND_NAL_END)
    else $error("missing unit end at end of stream");

endmodule

// ===== src/anb_step.sv =====
module anb_step (
  input  anb_pkg::anb_state_t st,
  input  anb_pkg::anb_in_t    item,
  output anb_pkg::anb_state_t st_next,
  output logic                emit,
  output anb_pkg::anb_out_t   res
);
  import anb_pkg::*;

  logic             run_full;
  logic             is_start;
  logic             is_epb;
  logic [SIZE_BITS-1:0] epb_pos;

  assign run_full = (st.zero_run == ZERO_RUN_FULL);
  assign is_start = run_full && (item.in_byte == STC_BYTE);
  assign is_epb   = run_full && (item.in_byte == EPB_BYTE);
  assign epb_pos  = (st.payload_count != '0) ? st.payload_count - SIZE_BITS'(1) : '0;

  // next state and result for one byte
  always_comb begin
    st_next = st;
    emit    = 1'b0;
    res     = '0;
    res.kind = KIND_PAYLOAD;
    if (item.end_of_stream) begin
      // close open unit at end of stream
      emit         = st.unit_open;
      res.kind     = KIND_NAL_END;
      res.nal_type = st.header_type;
      res.nal_size = SIZE_W'(st.payload_count);
      res.epb_count = COUNT_W'(st.removed_count);
      st_next      = STATE_RESET;
    end else if (is_start) begin
      // start code closes the open unit and opens a new one
      emit          = st.unit_open;
      res.kind      = KIND_NAL_END;
      res.nal_type  = st.header_type;
      res.nal_size  = SIZE_W'(st.payload_count);
      res.epb_count = COUNT_W'(st.removed_count);
      st_next           = STATE_RESET;
      st_next.unit_open = 1'b1;
    end else if (is_epb) begin
      // emulation prevention byte dropped
      st_next.zero_run = 2'd0;
      if (st.unit_open) begin
        emit             = 1'b1;
        res.kind         = KIND_EPB;
        res.epb_position = POS_W'(epb_pos);
        if (st.removed_count != COUNT_MAX) begin
          st_next.removed_count = st.removed_count + EPB_COUNT_BITS'(1);
        end
      end
    end else begin
      // ordinary byte
      if (item.in_byte == ZERO_BYTE) begin
        if (!run_full) begin
          st_next.zero_run = st.zero_run + 2'd1;
        end
      end else begin
        st_next.zero_run = 2'd0;
      end
      if (st.unit_open) begin
        emit          = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = item.in_byte;
        if (st.payload_count == HDR_INDEX) begin
          st_next.header_type = item.in_byte[7:3];
        end
        if (st.payload_count != SIZE_MAX) begin
          st_next.payload_count = st.payload_count + SIZE_BITS'(1);
        end
      end
    end
  end

endmodule
